>>> rtl/b64e_pkg.sv
// shared types, register indexes and the base64 alphabet for the stream encoder
package b64e_pkg;

	localparam int unsigned LC_W     = 10;
	localparam int unsigned CAP_W    = 32;
	localparam int unsigned COL_W    = 11;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_COLUMNS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'b1;

	localparam logic [LC_W-1:0]  LINE_COLUMNS_RST    = 10'd76;
	localparam logic [CAP_W-1:0] OUTPUT_CAPACITY_RST = 32'hFFFF_FFFF;

	localparam logic [7:0] NL_CHAR  = 8'h0A;
	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [COL_W-1:0] COL_MAX = 11'd2047;

	// one queue entry: the characters that one input beat causes
	typedef struct packed {
		logic [23:0] word;
		logic        has_grp;
		logic [1:0]  pads;
		logic        has_nl;
		logic        last;
	} cmd_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s} - 8'd26;
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s} - 8'd52;
		end else if (s == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

>>> rtl/b64e_in_if.sv
// input channel: one raw source byte per beat
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/b64e_out_if.sv
// output channel: one encoded character per beat
interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_end;
	logic       stream_end;

	modport source(output valid, output out_char, output run_end, output stream_end,
		input ready);
	modport sink(input valid, input out_char, input run_end, input stream_end,
		output ready);
endinterface

>>> rtl/b64e_front.sv
// front end: accepts source bytes, tracks group, line and capacity state, issues commands
module b64e_front (
	input  logic                        clk,
	input  logic                        arst_n,
	b64e_in_if.sink                     in_ch,
	input  logic [b64e_pkg::LC_W-1:0]   line_columns,
	input  logic [b64e_pkg::CAP_W-1:0]  output_capacity,
	input  logic                        q_full,
	output logic                        q_push,
	output b64e_pkg::cmd_t              q_cmd
);
	import b64e_pkg::*;

	logic [15:0]      pending_q;
	logic [1:0]       fill_q;
	logic [COL_W-1:0] col_q;
	logic [CAP_W-1:0] chars_q;

	logic             accept;
	logic [CAP_W:0]   room;
	logic             room_neg;
	logic             ge2, ge4, ge5, ge6;
	logic             lc_on, take, grp, pad, nl_grp, nl_fin, adv;
	logic [COL_W:0]   col_sum;
	logic [COL_W-1:0] col_sat, col1;
	logic [15:0]      pending1;
	logic [1:0]       fill1;
	logic [CAP_W-1:0] chars_next;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// headroom left in the destination, negative when already past capacity
	assign room     = {1'b0, output_capacity} - {1'b0, chars_q};
	assign room_neg = room[CAP_W];
	assign ge2      = !room_neg && (room[CAP_W-1:0] >= 32'd2);
	assign ge4      = !room_neg && (room[CAP_W-1:0] >= 32'd4);
	assign ge5      = !room_neg && (room[CAP_W-1:0] >= 32'd5);
	assign ge6      = !room_neg && (room[CAP_W-1:0] >= 32'd6);

	assign lc_on   = line_columns != '0;
	assign take    = ge4;
	assign grp     = take && (fill_q == 2'd2);
	assign col_sum = {1'b0, col_q} + 12'd4;
	assign col_sat = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
	assign nl_grp  = grp && lc_on && (col_sat >= {1'b0, line_columns}) && ge5;

	always_comb begin
		col1     = col_q;
		pending1 = pending_q;
		fill1    = fill_q;
		if (grp) begin
			pending1 = '0;
			fill1    = 2'd0;
			if (lc_on) begin
				col1 = nl_grp ? '0 : col_sat;
			end
		end else if (take) begin
			pending1 = {pending_q[7:0], in_ch.data_byte};
			fill1    = fill_q + 2'd1;
		end
	end

	assign pad    = in_ch.last_byte && !grp && (fill1 != 2'd0) && take;
	assign adv    = grp || pad;
	assign nl_fin = in_ch.last_byte && lc_on && ((col1 != '0) || (fill1 != 2'd0)) &&
		(adv ? ge6 : ge2);

	assign chars_next = chars_q + (adv ? 32'd4 : 32'd0) + {31'd0, nl_grp};

	always_comb begin
		q_cmd.has_grp = adv;
		q_cmd.has_nl  = nl_grp || nl_fin;
		q_cmd.last    = in_ch.last_byte;
		q_cmd.pads    = 2'd0;
		if (grp) begin
			q_cmd.word = {pending_q, in_ch.data_byte};
		end else if (fill1 == 2'd1) begin
			q_cmd.word = {pending1[7:0], 16'd0};
		end else begin
			q_cmd.word = {pending1, 8'd0};
		end
		if (pad) begin
			q_cmd.pads = (fill1 == 2'd1) ? 2'd2 : 2'd1;
		end
	end

	assign q_push = accept && (q_cmd.has_grp || q_cmd.has_nl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			fill_q    <= '0;
			col_q     <= '0;
			chars_q   <= '0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				pending_q <= '0;
				fill_q    <= '0;
				col_q     <= '0;
				chars_q   <= '0;
			end else begin
				pending_q <= pending1;
				fill_q    <= fill1;
				col_q     <= col1;
				chars_q   <= chars_next;
			end
		end
	end

endmodule

>>> rtl/b64e_fifo.sv
// short command queue between front and back
module b64e_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output b64e_pkg::cmd_t head_cmd,
	output logic           empty
);
	import b64e_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = count_q == CNT_FULL;
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/b64e_back.sv
// back end: walks each command one character per cycle into the output register unless stalled
module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64e_pkg::cmd_t head_cmd,
	input  logic           q_empty,
	output logic           q_pop,
	b64e_out_if.source     out_ch
);
	import b64e_pkg::*;

	logic [2:0] slot_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       run_end_q, stream_end_q;

	logic [2:0] last_slot;
	logic       fire, final_slot, is_pad;
	logic [1:0] idx;
	logic [5:0] sextet;
	logic [7:0] next_char;

	assign last_slot  = head_cmd.has_grp ? (head_cmd.has_nl ? 3'd4 : 3'd3) : 3'd0;
	assign final_slot = slot_q == last_slot;
	assign fire       = !q_empty && (!out_valid_q || out_ch.ready);
	assign q_pop      = fire && final_slot;
	assign idx        = slot_q[1:0];

	always_comb begin
		unique case (idx)
			2'd0: sextet = head_cmd.word[23:18];
			2'd1: sextet = head_cmd.word[17:12];
			2'd2: sextet = head_cmd.word[11:6];
			2'd3: sextet = head_cmd.word[5:0];
		endcase
	end

	assign is_pad = ((head_cmd.pads == 2'd2) && (idx >= 2'd2)) ||
		((head_cmd.pads == 2'd1) && (idx == 2'd3));

	always_comb begin
		if (head_cmd.has_grp && !slot_q[2]) begin
			next_char = is_pad ? PAD_CHAR : sextet_char(sextet);
		end else begin
			next_char = NL_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				slot_q      <= final_slot ? 3'd0 : slot_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q       <= next_char;
			run_end_q    <= final_slot;
			stream_end_q <= final_slot && head_cmd.last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_char   = char_q;
	assign out_ch.run_end    = run_end_q;
	assign out_ch.stream_end = stream_end_q;

endmodule

>>> rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder: config registers, front, queue and back
//
//  channel  dir  beat                                   handshake
//  in_ch    in   data_byte[8], last_byte                valid/ready
//  out_ch   out  out_char[8], run_end, stream_end       valid/ready
//  cfg      in   cfg_index[1], cfg_data[32]             cfg_wr_en, no wait
//
// the front takes one byte per cycle while the queue has room; the back emits one
// character per cycle unless stalled: a byte gives 0 to 5 chars, 4/3 on average
// reset (arst_n low) clears the stream state, the queue and the output valid and
// loads line_columns 76 and output_capacity all ones
// an output stall fills the queue, then the front stops taking bytes
module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [b64e_pkg::CAP_W-1:0]      cfg_data,
	b64e_in_if.sink                         in_ch,
	b64e_out_if.source                      out_ch
);
	import b64e_pkg::*;

	logic [LC_W-1:0]  line_columns_q;
	logic [CAP_W-1:0] output_capacity_q;

	logic q_full, q_push, q_pop, q_empty;
	cmd_t push_cmd, head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_columns_q    <= LINE_COLUMNS_RST;
			output_capacity_q <= OUTPUT_CAPACITY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_COLUMNS:    line_columns_q    <= cfg_data[LC_W-1:0];
				REG_OUTPUT_CAPACITY: output_capacity_q <= cfg_data;
			endcase
		end
	end

	b64e_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.line_columns    (line_columns_q),
		.output_capacity (output_capacity_q),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_cmd           (push_cmd)
	);

	b64e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_ch   (out_ch)
	);

endmodule
